// File: rtl/core/sfrc_pkg.sv
// Package for the stuffed frame receiver: register map, reset values, CRC-16 byte update.
package sfrc_pkg;

    // Register map (byte address = 4 * index)
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_START_BYTE    = 2'd0;
    localparam logic [1:0] REG_ESCAPE_BYTE   = 2'd1;
    localparam logic [1:0] REG_LENGTH_OFFSET = 2'd2;

    // Register reset values
    localparam logic [7:0] START_BYTE_RST    = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE_RST   = 8'h7D;
    localparam logic [3:0] LENGTH_OFFSET_RST = 4'd1;

    // CRC-16 constants
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Frame byte counter width and its saturation value
    localparam int unsigned CNT_W = 9;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One byte into the CRC, data bits LSB first, shifted in at bit 0
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        top;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            top = c[15];
            c   = {c[14:0], b[k]};
            if (top)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/stuffed_frame_receiver_crc16.sv
// Byte-stuffed frame receiver with CRC-16 check and APB register port.
// Each accepted rx_byte beat passes the input register, then the result register.
// Throughput: one byte per cycle while out_stall does not hold a full result register;
//   the CRC byte update is unrolled in one stage.
// Bytes that make no result (hunting, escapes) still pass through the input stage.
// Reset (rst_n low, asynchronous): hunting for a start byte, registers at their defaults.
module stuffed_frame_receiver_crc16 (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // received byte channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    // frame byte channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    frame_byte,
    output logic                          frame_first,
    output logic                          frame_last,
    output logic                          crc_good
);

    // Configuration registers
    logic [7:0] start_byte_reg;
    logic [7:0] escape_byte_reg;
    logic [3:0] length_offset_reg;

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_adv;
    logic       in_accept;

    // Receiver state
    logic                         in_frame_reg, in_frame_next;
    logic                         esc_pending_reg, esc_pending_next;
    logic [sfrc_pkg::CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [7:0]                   payload_len_reg, payload_len_next;
    logic [15:0]                  crc_reg, crc_next;
    logic [15:0]                  trailing_reg, trailing_next;

    // Result register
    logic       out_valid_reg;
    logic [7:0] frame_byte_reg;
    logic       frame_first_reg;
    logic       frame_last_reg;
    logic       crc_good_reg;

    // Combinational decode of the byte in the input stage
    logic                         hit_start;
    logic                         hit_escape;
    logic                         do_open;
    logic                         do_take;
    logic [sfrc_pkg::CNT_W-1:0]   idx;
    logic [7:0]                   plen_eff;
    logic [15:0]                  crc_eff;
    logic [15:0]                  trail_eff;
    logic [sfrc_pkg::CNT_W-1:0]   data_end;
    logic                         is_last;
    logic                         is_good;
    logic                         cfg_write;

    // APB: always ready, registers decoded on word index
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg    <= sfrc_pkg::START_BYTE_RST;
            escape_byte_reg   <= sfrc_pkg::ESCAPE_BYTE_RST;
            length_offset_reg <= sfrc_pkg::LENGTH_OFFSET_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                sfrc_pkg::REG_START_BYTE:    start_byte_reg    <= pwdata[7:0];
                sfrc_pkg::REG_ESCAPE_BYTE:   escape_byte_reg   <= pwdata[7:0];
                sfrc_pkg::REG_LENGTH_OFFSET: length_offset_reg <= pwdata[3:0];
                default:                     ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            sfrc_pkg::REG_START_BYTE:    prdata = {24'd0, start_byte_reg};
            sfrc_pkg::REG_ESCAPE_BYTE:   prdata = {24'd0, escape_byte_reg};
            sfrc_pkg::REG_LENGTH_OFFSET: prdata = {28'd0, length_offset_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Handshake: the input stage moves on whenever the result register is free or draining
    assign s1_adv    = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall  = s1_valid_reg & ~s1_adv;
    assign in_accept = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // Deframing: start / escape handling, length pickup, CRC and trailer compare
    always_comb
    begin
        hit_start  = (s1_byte_reg == start_byte_reg);
        hit_escape = (s1_byte_reg == escape_byte_reg);

        in_frame_next    = in_frame_reg;
        esc_pending_next = esc_pending_reg;
        byte_count_next  = byte_count_reg;
        payload_len_next = payload_len_reg;
        crc_next         = crc_reg;
        trailing_next    = trailing_reg;

        do_open = 1'b0;
        do_take = 1'b0;
        if (!in_frame_reg)
        begin
            do_open = hit_start;
        end
        else if (esc_pending_reg)
        begin
            do_take          = 1'b1;
            esc_pending_next = 1'b0;
        end
        else if (hit_start)
        begin
            do_open = 1'b1;
        end
        else if (hit_escape)
        begin
            esc_pending_next = 1'b1;
        end
        else
        begin
            do_take = 1'b1;
        end

        // A start byte restarts all frame state
        idx       = do_open ? '0 : byte_count_reg;
        plen_eff  = do_open ? 8'd0 : payload_len_reg;
        crc_eff   = do_open ? sfrc_pkg::CRC_INIT : crc_reg;
        trail_eff = do_open ? 16'd0 : trailing_reg;

        if (idx == {{(sfrc_pkg::CNT_W-4){1'b0}}, length_offset_reg})
        begin
            plen_eff = s1_byte_reg;
        end
        data_end = {{(sfrc_pkg::CNT_W-4){1'b0}}, length_offset_reg}
                 + {{(sfrc_pkg::CNT_W-8){1'b0}}, plen_eff};

        is_last = 1'b0;
        is_good = 1'b0;
        if (idx != '0)
        begin
            if (idx <= data_end)
            begin
                crc_eff = sfrc_pkg::crc_feed(crc_eff, s1_byte_reg);
            end
            else if ({1'b0, idx} == ({1'b0, data_end} + 1'b1))
            begin
                trail_eff = {8'd0, s1_byte_reg};
            end
            else
            begin
                is_last = 1'b1;
                is_good = ({s1_byte_reg, trail_eff[7:0]} == crc_eff);
            end
        end

        if (do_open || do_take)
        begin
            payload_len_next = plen_eff;
            crc_next         = crc_eff;
            trailing_next    = trail_eff;
            byte_count_next  = (idx != sfrc_pkg::CNT_MAX) ? idx + 1'b1 : idx;
            if (do_open)
            begin
                in_frame_next    = 1'b1;
                esc_pending_next = 1'b0;
            end
            if (is_last)
            begin
                in_frame_next    = 1'b0;
                esc_pending_next = 1'b0;
            end
        end
    end

    // Receiver state update, one byte per advance of the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            esc_pending_reg <= 1'b0;
            byte_count_reg  <= '0;
            payload_len_reg <= 8'd0;
            crc_reg         <= sfrc_pkg::CRC_INIT;
            trailing_reg    <= 16'd0;
        end
        else if (s1_adv)
        begin
            in_frame_reg    <= in_frame_next;
            esc_pending_reg <= esc_pending_next;
            byte_count_reg  <= byte_count_next;
            payload_len_reg <= payload_len_next;
            crc_reg         <= crc_next;
            trailing_reg    <= trailing_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= do_open | do_take;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && (do_open || do_take))
        begin
            frame_byte_reg  <= s1_byte_reg;
            frame_first_reg <= do_open;
            frame_last_reg  <= is_last;
            crc_good_reg    <= is_good;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = frame_byte_reg;
    assign frame_first = frame_first_reg;
    assign frame_last  = frame_last_reg;
    assign crc_good    = crc_good_reg;

endmodule

// File: sim/frame_checker.sv
// Frame receiver checker: CRC helper package, byte-level predictor and result scoreboard.
`timescale 1ns / 1ps

package frame_tb_pkg;

    // CRC-16 over one byte, data bits taken LSB first into bit 0
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[15];
            r  = {r[14:0], d[i]} ^ ({16{fb}} & sfrc_pkg::CRC_POLY);
        end
        return r;
    endfunction

endpackage

module frame_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration bus, watched only
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [sfrc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    // received byte channel
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [7:0]                  rx_byte,
    // frame byte channel
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [7:0]                  frame_byte,
    input  logic                        frame_first,
    input  logic                        frame_last,
    input  logic                        crc_good,
    output int                          fail_cnt,
    output int                          pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       eof;
        logic       ok;
    } frame_beat_t;

    // frame beats predicted but not yet seen on the output
    frame_beat_t expected_beats[$];
    frame_beat_t got_beat;
    frame_beat_t want_beat;

    // register copies
    logic [7:0]       start_cfg;
    logic [7:0]       esc_cfg;
    logic [3:0]       off_cfg;

    // deframer state
    logic                       in_frame;
    logic                       esc_pend;
    logic [sfrc_pkg::CNT_W-1:0] frame_idx;
    logic [7:0]                 pay_len;
    logic [15:0]                crc_acc;
    logic [7:0]                 crc_lo;

    // one unescaped frame byte: length capture, CRC, trailer compare
    task automatic take_frame_byte(input logic [7:0] b, input logic sof);
        int          idx;
        int          data_end;
        frame_beat_t beat;
        idx       = int'(frame_idx);
        beat.data = b;
        beat.sof  = sof;
        beat.eof  = 1'b0;
        beat.ok   = 1'b0;
        if (idx == off_cfg)
            pay_len = b;
        if (idx >= 1)
        begin
            data_end = int'(off_cfg) + int'(pay_len);
            if (idx <= data_end)
                crc_acc = frame_tb_pkg::crc16_step(crc_acc, b);
            else if (idx == data_end + 1)
                crc_lo = b;
            else
            begin
                beat.eof = 1'b1;
                beat.ok  = ({b, crc_lo} == crc_acc);
                in_frame = 1'b0;
                esc_pend = 1'b0;
            end
        end
        if (idx < int'(sfrc_pkg::CNT_MAX))
            frame_idx = frame_idx + 1'b1;
        expected_beats = {expected_beats, beat};
    endtask

    task automatic open_frame(input logic [7:0] b);
        in_frame  = 1'b1;
        esc_pend  = 1'b0;
        frame_idx = '0;
        pay_len   = '0;
        crc_acc   = sfrc_pkg::CRC_INIT;
        crc_lo    = '0;
        take_frame_byte(b, 1'b1);
    endtask

    // raw link byte: hunting, escape removal, restart on start byte
    task automatic deframe_rx_byte(input logic [7:0] b);
        if (!in_frame)
        begin
            if (b == start_cfg)
                open_frame(b);
        end
        else if (esc_pend)
        begin
            esc_pend = 1'b0;
            take_frame_byte(b, 1'b0);
        end
        else if (b == start_cfg)
            open_frame(b);
        else if (b == esc_cfg)
            esc_pend = 1'b1;
        else
            take_frame_byte(b, 1'b0);
    endtask

    // output compare first, then new input beat, then register write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_cfg = sfrc_pkg::START_BYTE_RST;
            esc_cfg   = sfrc_pkg::ESCAPE_BYTE_RST;
            off_cfg   = sfrc_pkg::LENGTH_OFFSET_RST;
            in_frame  = 1'b0;
            esc_pend  = 1'b0;
            frame_idx = '0;
            pay_len   = '0;
            crc_acc   = sfrc_pkg::CRC_INIT;
            crc_lo    = '0;
            expected_beats.delete();
            fail_cnt  = 0;
            pending   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_beat.data = frame_byte;
                got_beat.sof  = frame_first;
                got_beat.eof  = frame_last;
                got_beat.ok   = crc_good;
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: extra beat: expected none, got byte %h first %b last %b crc %b",
                             $time, frame_byte, frame_first, frame_last, crc_good);
                    fail_cnt++;
                end
                else
                begin
                    want_beat = expected_beats.pop_front();
                    if (got_beat !== want_beat)
                    begin
                        $display("%0t: beat mismatch: expected byte %h first %b last %b crc %b",
                                 $time, want_beat.data, want_beat.sof, want_beat.eof,
                                 want_beat.ok);
                        $display("%0t:                got      byte %h first %b last %b crc %b",
                                 $time, got_beat.data, got_beat.sof, got_beat.eof,
                                 got_beat.ok);
                        fail_cnt++;
                    end
                end
            end
            if (in_valid && !in_stall)
                deframe_rx_byte(rx_byte);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    sfrc_pkg::REG_START_BYTE:    start_cfg = pwdata[7:0];
                    sfrc_pkg::REG_ESCAPE_BYTE:   esc_cfg   = pwdata[7:0];
                    sfrc_pkg::REG_LENGTH_OFFSET: off_cfg   = pwdata[3:0];
                    default: ;
                endcase
            end
            pending = expected_beats.size();
        end
    end

endmodule

// File: sim/tb_top.sv
// Testbench top for the stuffed frame receiver: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sfrc_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_stall;
    logic [7:0]                    rx_byte;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [7:0]                    frame_byte;
    logic                          frame_first;
    logic                          frame_last;
    logic                          crc_good;

    int                  fail_cnt;
    int                  pending;
    int                  beats_sent;
    bit                  calm;

    // settings currently in the block, used to build frames
    logic [7:0]          cur_start;
    logic [7:0]          cur_esc;
    logic [3:0]          cur_off;

    stuffed_frame_receiver_crc16 i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .frame_first (frame_first),
        .frame_last  (frame_last),
        .crc_good    (crc_good)
    );

    frame_checker i_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .frame_first (frame_first),
        .frame_last  (frame_last),
        .crc_good    (crc_good),
        .fail_cnt    (fail_cnt),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver back-pressure, off during calm stretches
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end

    // one raw byte beat, with an occasional gap before it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 13)
        begin
            gap      = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        beats_sent++;
    endtask

    // stop sending and wait until every predicted beat has come out
    task automatic drain_frames();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [3:0] o);
        reg_write(sfrc_pkg::REG_START_BYTE, {24'd0, s});
        reg_write(sfrc_pkg::REG_ESCAPE_BYTE, {24'd0, e});
        reg_write(sfrc_pkg::REG_LENGTH_OFFSET, {28'd0, o});
        cur_start = s;
        cur_esc   = e;
        cur_off   = o;
    endtask

    // Build one frame, append its CRC, optionally damage or truncate it, then stuff
    // and send it. The special fill cycles through start, escape, 0x00 and 0xFF.
    task automatic send_frame(input int len, input bit corrupt, input int cut, input bit special);
        logic [7:0]  fr[$];
        logic [7:0]  b;
        logic [15:0] acc;
        int          lval;
        int          n;
        fr   = {fr, cur_start};
        lval = (cur_off == 0) ? int'(cur_start) : len;
        for (int i = 1; i <= cur_off + lval; i++)
        begin
            if (i == cur_off)
                b = lval[7:0];
            else if (special)
            begin
                case (i % 4)
                    0:       b = cur_start;
                    1:       b = cur_esc;
                    2:       b = 8'h00;
                    default: b = 8'hFF;
                endcase
            end
            else
                b = 8'($urandom_range(0, 255));
            fr = {fr, b};
        end
        acc = sfrc_pkg::CRC_INIT;
        for (int i = 1; i < fr.size(); i++)
            acc = frame_tb_pkg::crc16_step(acc, fr[i]);
        fr = {fr, acc[7:0]};
        fr = {fr, acc[15:8]};
        if (corrupt)
        begin
            n     = fr.size() - 1 - $urandom_range(0, 1);
            fr[n] = fr[n] ^ (8'd1 << $urandom_range(0, 7));
        end
        n = (cut > 0 && cut < fr.size()) ? cut : fr.size();
        send_byte(fr[0]);
        for (int i = 1; i < n; i++)
        begin
            if (fr[i] == cur_start || fr[i] == cur_esc)
                send_byte(cur_esc);
            send_byte(fr[i]);
        end
    endtask

    // mostly good frames with random content; the rest bad CRC, cut frames, line noise
    task automatic run_random(input int nbytes);
        int target;
        int r;
        int len;
        int cnt;
        target = beats_sent + nbytes;
        while (beats_sent < target)
        begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
            if (r < 65)
                send_frame(len, 1'b0, 0, $urandom_range(0, 3) == 0);
            else if (r < 78)
                send_frame(len, 1'b1, 0, 1'b0);
            else if (r < 88)
                send_frame(len, 1'b0, $urandom_range(1, len + 4), 1'b0);
            else
            begin
                cnt = $urandom_range(1, 5);
                repeat (cnt)
                    send_byte($urandom_range(0, 3) == 0 ? cur_esc : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        calm       = 1'b0;
        beats_sent = 0;
        cur_start  = sfrc_pkg::START_BYTE_RST;
        cur_esc    = sfrc_pkg::ESCAPE_BYTE_RST;
        cur_off    = sfrc_pkg::LENGTH_OFFSET_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: noise and escape while hunting, minimal frame, stuffed
        // start/escape in payload, cut frame with restart, bad CRC
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sfrc_pkg::ESCAPE_BYTE_RST);
        send_frame(0, 1'b0, 0, 1'b0);
        send_frame(4, 1'b0, 0, 1'b1);
        send_frame(5, 1'b0, 4, 1'b0);
        send_frame(1, 1'b0, 0, 1'b0);
        send_frame(2, 1'b1, 0, 1'b0);

        // sender holds off until the output side has fully drained
        drain_frames();
        run_random(125);

        for (int p = 1; p < 8; p++)
        begin
            drain_frames();
            case (p)
                1:       set_config(8'h00, 8'hFF, 4'd15);
                2:       set_config(8'hFF, 8'h00, 4'd1);
                3:       set_config(8'h7E, 8'h7E, 4'd2);
                4:       set_config(8'($urandom_range(0, 20)), 8'($urandom_range(21, 255)), 4'd0);
                default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    4'($urandom_range(1, 15)));
            endcase
            calm = (p == 2);
            if (p == 1)
                send_frame(255, 1'b0, 0, 1'b0);
            run_random(125);
        end

        drain_frames();
        repeat (6) @(posedge clk);
        if (fail_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
